// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== rtl/core/qfc_pkg.sv =====
// Package: types, constants and codes of the quantum frequency counter.
`timescale 1ns / 1ps
package qfc_pkg;

    // Table size, power of two between 16 and 65536.
    localparam int SLOTS    = 1024;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int PCNT_W   = IDX_W + 1;
    localparam int KEY_W    = 64;
    localparam int FREQ_W   = 32;
    localparam int TOTAL_W  = 32;
    localparam int UNIQUE_W = 11;
    localparam int QB_W     = 4;
    localparam int POS_W    = 3;
    localparam int SLOT_IN_W = 10;

    localparam logic [QB_W-1:0] QB_RESET = QB_W'(1);

    typedef enum logic [2:0] {
        STAT_ABSORBED = 3'd0,
        STAT_COUNTED  = 3'd1,
        STAT_NEW      = 3'd2,
        STAT_DROPPED  = 3'd3,
        STAT_READ     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [FREQ_W-1:0] count;
    } entry_t;

    typedef struct packed {
        status_t             status;
        logic [KEY_W-1:0]    value;
        logic [FREQ_W-1:0]   freq;
        logic                entry_valid;
        logic [TOTAL_W-1:0]  total;
        logic [UNIQUE_W-1:0] unique_cnt;
    } result_t;

    typedef struct packed {
        logic             complete;
        logic [KEY_W-1:0] word;
    } asm_t;

endpackage

// ===== rtl/core/qfc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module qfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/qfc_assembler.sv =====
// Little-endian quantum assembly from the byte stream.
`timescale 1ns / 1ps
module qfc_assembler
    import qfc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            take,
    input  logic [7:0]      data_byte,
    input  logic [QB_W-1:0] quantum_bytes,
    output asm_t            asm_out
);

    logic [KEY_W-1:0] assembly_reg, assembly_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [QB_W-1:0]  eff_size;
    logic [KEY_W-1:0] word;
    logic             complete;

    always_comb begin
        if (quantum_bytes == '0) begin
            eff_size = QB_W'(1);
        end else if (quantum_bytes > QB_W'(8)) begin
            eff_size = QB_W'(8);
        end else begin
            eff_size = quantum_bytes;
        end
        word     = assembly_reg | (KEY_W'(data_byte) << {pos_reg, 3'b000});
        complete = (QB_W'(pos_reg) + QB_W'(1)) >= eff_size;

        assembly_next = assembly_reg;
        pos_next      = pos_reg;
        if (take) begin
            if (complete) begin
                assembly_next = '0;
                pos_next      = '0;
            end else begin
                assembly_next = word;
                pos_next      = pos_reg + POS_W'(1);
            end
        end
    end

    assign asm_out.complete = complete;
    assign asm_out.word     = word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            assembly_reg <= '0;
            pos_reg      <= '0;
        end else begin
            assembly_reg <= assembly_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ===== rtl/core/quantum_frequency_counter.sv =====
// Quantum frequency counter: hash table of quantum counts with linear probing.
// Usage:
//   s_ channel (valid/ready) takes one item: s_mode 0 counts s_data_byte,
//   s_mode 1 reads table slot s_slot_index. Each item gives one m_ item.
//   cfg_wr_en/cfg_wr_data set the quantum size in bytes; write only when idle.
// From acceptance to m_valid: an absorbed byte passes ST_EMIT, a read ST_READ
//   and ST_EMIT, a completed quantum that probes P slots (P from 1 to 1024)
//   ST_CHECK and ST_EMIT. A new item waits until the last leaves ST_EMIT;
//   the single memory read port, one probe per cycle, sets the counting rate.
// Reset: a clearing pass writes all 1024 table slots, one per cycle, and
//   s_ready stays low until it ends; counters and assembly clear.
// Stall: the result sits in an output register; the next item is accepted
//   and worked on while it waits, and its own result holds until m_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quantum_frequency_counter
    import qfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [QB_W-1:0]      cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [7:0]           s_data_byte,
    input  logic [SLOT_IN_W-1:0] s_slot_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [KEY_W-1:0]     m_quantum_value,
    output logic [FREQ_W-1:0]    m_frequency,
    output logic                 m_entry_valid,
    output logic [TOTAL_W-1:0]   m_total_quanta,
    output logic [UNIQUE_W-1:0]  m_unique_quanta
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [PCNT_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                in_range_reg, in_range_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [UNIQUE_W-1:0] unique_reg, unique_next;
    logic [QB_W-1:0]     qbytes_reg;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    entry_t              mem_wdata, mem_rdata;
    logic                asm_take;
    asm_t                asm_out;
    logic [TOTAL_W-1:0]  total_inc;
    logic [UNIQUE_W-1:0] unique_inc;
    logic [FREQ_W-1:0]   count_inc;

    qfc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qfc_assembler u_asm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (asm_take),
        .data_byte     (s_data_byte),
        .quantum_bytes (qbytes_reg),
        .asm_out       (asm_out)
    );

    assign total_inc  = (total_reg == '1) ? total_reg : total_reg + TOTAL_W'(1);
    assign unique_inc = (unique_reg == '1) ? unique_reg : unique_reg + UNIQUE_W'(1);
    assign count_inc  = (mem_rdata.count == '1) ? mem_rdata.count
                                                : mem_rdata.count + FREQ_W'(1);

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        key_next       = key_reg;
        in_range_next  = in_range_reg;
        total_next     = total_reg;
        unique_next    = unique_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = (state_reg == ST_IDLE);
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = slot_reg;
        asm_take       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode) begin
                        mem_re        = 1'b1;
                        mem_raddr     = IDX_W'(s_slot_index);
                        in_range_next = (32'(s_slot_index) < 32'(SLOTS));
                        state_next    = ST_READ;
                    end else begin
                        asm_take = 1'b1;
                        if (asm_out.complete) begin
                            key_next       = asm_out.word;
                            slot_next      = asm_out.word[IDX_W-1:0];
                            probe_cnt_next = '0;
                            mem_re         = 1'b1;
                            mem_raddr      = asm_out.word[IDX_W-1:0];
                            state_next     = ST_CHECK;
                        end else begin
                            res_next.status      = STAT_ABSORBED;
                            res_next.value       = '0;
                            res_next.freq        = '0;
                            res_next.entry_valid = 1'b0;
                            res_next.total       = total_reg;
                            res_next.unique_cnt  = unique_reg;
                            state_next           = ST_EMIT;
                        end
                    end
                end
            end
            ST_READ: begin
                res_next.status     = STAT_READ;
                res_next.total      = total_reg;
                res_next.unique_cnt = unique_reg;
                if (in_range_reg && mem_rdata.valid) begin
                    res_next.entry_valid = 1'b1;
                    res_next.value       = mem_rdata.key;
                    res_next.freq        = mem_rdata.count;
                end else begin
                    res_next.entry_valid = 1'b0;
                    res_next.value       = '0;
                    res_next.freq        = '0;
                end
                state_next = ST_EMIT;
            end
            ST_CHECK: begin
                res_next.value       = key_reg;
                res_next.entry_valid = 1'b0;
                if (!mem_rdata.valid) begin
                    mem_we              = 1'b1;
                    mem_wdata.valid     = 1'b1;
                    mem_wdata.key       = key_reg;
                    mem_wdata.count     = FREQ_W'(1);
                    total_next          = total_inc;
                    unique_next         = unique_inc;
                    res_next.status     = STAT_NEW;
                    res_next.freq       = FREQ_W'(1);
                    res_next.total      = total_inc;
                    res_next.unique_cnt = unique_inc;
                    state_next          = ST_EMIT;
                end else if (mem_rdata.key == key_reg) begin
                    mem_we              = 1'b1;
                    mem_wdata.valid     = 1'b1;
                    mem_wdata.key       = key_reg;
                    mem_wdata.count     = count_inc;
                    total_next          = total_inc;
                    res_next.status     = STAT_COUNTED;
                    res_next.freq       = count_inc;
                    res_next.total      = total_inc;
                    res_next.unique_cnt = unique_reg;
                    state_next          = ST_EMIT;
                end else if (probe_cnt_reg == PCNT_W'(SLOTS - 1)) begin
                    res_next.status     = STAT_DROPPED;
                    res_next.freq       = '0;
                    res_next.total      = total_reg;
                    res_next.unique_cnt = unique_reg;
                    state_next          = ST_EMIT;
                end else begin
                    slot_next      = slot_reg + IDX_W'(1);
                    probe_cnt_next = probe_cnt_reg + PCNT_W'(1);
                    mem_re         = 1'b1;
                    mem_raddr      = slot_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            unique_reg    <= '0;
            qbytes_reg    <= QB_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            total_reg     <= total_next;
            unique_reg    <= unique_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                qbytes_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        key_reg       <= key_next;
        in_range_reg  <= in_range_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_quantum_value = out_reg.value;
    assign m_frequency     = out_reg.freq;
    assign m_entry_valid   = out_reg.entry_valid;
    assign m_total_quanta  = out_reg.total;
    assign m_unique_quanta = out_reg.unique_cnt;

    `ASSERT_IMPLIES(a_unique_bound, aclk, aresetn, 1'b1, 32'(unique_reg) <= 32'(SLOTS))
    `ASSERT_IMPLIES(a_write_states, aclk, aresetn, mem_we, (state_reg == ST_CLEAR) || (state_reg == ST_CHECK))
    `ASSERT_IMPLIES(a_probe_bound, aclk, aresetn, state_reg == ST_CHECK, 32'(probe_cnt_reg) < 32'(SLOTS))
    `ASSERT_NEXT(a_out_from_emit, aclk, aresetn, (state_reg != ST_EMIT) && !m_valid_reg, !m_valid_reg)

endmodule
